// ----- src/sbot_pkg.sv -----
`default_nettype none
package sbot_pkg;

  localparam int BUFFER_COUNT = 16;
  localparam int CLIENT_SLOTS = 8;
  localparam int CREDIT_MAX   = 255;
  localparam int MAX_RESULTS  = 16;

  localparam int IDX_W  = 4;
  localparam int SLOT_W = 3;
  localparam int SEQ_W  = 32;
  localparam int TS_W   = 64;

  localparam int BUF_AW  = (BUFFER_COUNT > 1) ? $clog2(BUFFER_COUNT) : 1;
  localparam int SLOT_AW = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
  localparam int MASK_W  = CLIENT_SLOTS + 1;
  localparam int CRD_W   = $clog2(CREDIT_MAX + 1);
  localparam int CNT_W   = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    MODE_CONSUME = 2'd0,
    MODE_REDEEM  = 2'd1,
    MODE_RELEASE = 2'd2,
    MODE_CONNECT = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    KIND_DELIVER  = 3'd0,
    KIND_RETURN   = 3'd1,
    KIND_ASSIGNED = 3'd2,
    KIND_NOSLOT   = 3'd3,
    KIND_ERROR    = 3'd4
  } kind_t;

  typedef struct packed {
    mode_t              mode;
    logic [IDX_W-1:0]   buffer_index;
    logic [SLOT_W-1:0]  client_slot;
    logic               has_buffer;
    logic               add_credit;
    logic [SEQ_W-1:0]   frame_sequence;
    logic [TS_W-1:0]    frame_timestamp;
  } in_word_t;

  typedef struct packed {
    kind_t              kind;
    logic [SLOT_W-1:0]  target_slot;
    logic [IDX_W-1:0]   result_buffer;
    logic [SEQ_W-1:0]   out_sequence;
    logic [TS_W-1:0]    out_timestamp;
    logic               last;
  } out_word_t;

  typedef struct packed {
    logic               we;
    logic [BUF_AW-1:0]  waddr;
    logic [MASK_W-1:0]  wdata;
    logic [BUF_AW-1:0]  raddr;
  } own_req_t;

  typedef struct packed {
    logic               we;
    logic [SLOT_AW-1:0] waddr;
    logic [CRD_W-1:0]   wdata;
    logic [SLOT_AW-1:0] raddr;
  } crd_req_t;

  function automatic logic buf_ok(logic [IDX_W-1:0] i);
    return 32'(i) < 32'(BUFFER_COUNT);
  endfunction

  function automatic logic slot_ok(logic [SLOT_W-1:0] s);
    return 32'(s) < 32'(CLIENT_SLOTS);
  endfunction

endpackage
`default_nettype wire

// ----- src/sbot_ram.sv -----
`default_nettype none
module sbot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- src/sbot_seq.sv -----
`default_nettype none
module sbot_seq import sbot_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_word_t         in_word,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_word_t             out_word,
  output own_req_t              own_req,
  input  wire logic [MASK_W-1:0] own_rdata,
  output crd_req_t              crd_req,
  input  wire logic [CRD_W-1:0] crd_rdata
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_CONS  = 7'b0000100,
    S_CFIN  = 7'b0001000,
    S_RDM   = 7'b0010000,
    S_REL   = 7'b0100000,
    S_FLUSH = 7'b1000000
  } state_t;

  function automatic out_word_t mk_word(kind_t k, logic [SLOT_W-1:0] s,
                                        logic [IDX_W-1:0] b, logic [SEQ_W-1:0] q,
                                        logic [TS_W-1:0] t);
    out_word_t w;
    w.kind          = k;
    w.target_slot   = s;
    w.result_buffer = b;
    w.out_sequence  = q;
    w.out_timestamp = t;
    w.last          = 1'b0;
    return w;
  endfunction

  function automatic logic [MASK_W-1:0] slot_bit(logic [SLOT_AW-1:0] s);
    return MASK_W'(2) << s;
  endfunction

  state_t               state_r, state_nxt;
  in_word_t             item_r, item_nxt;
  logic [SLOT_AW-1:0]   slot_r, slot_nxt;
  logic [BUF_AW-1:0]    buf_r, buf_nxt;
  logic [MASK_W-1:0]    mask_r, mask_nxt;
  logic [CNT_W-1:0]     n_r, n_nxt;
  logic                 pend_valid_r, pend_valid_nxt;
  out_word_t            pend_r, pend_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_word_t            out_r, out_nxt;
  logic [CLIENT_SLOTS-1:0] active_r, active_nxt;
  logic [BUFFER_COUNT-1:0] owner_vld_r, owner_vld_nxt;
  logic                 owner_rvld_r;

  logic [MASK_W-1:0]    owner_eff;
  logic                 free_found;
  logic [SLOT_AW-1:0]   free_slot;
  logic [SLOT_AW-1:0]   item_slot;
  logic [MASK_W-1:0]    item_bit;
  logic [MASK_W-1:0]    walk_bit;
  logic                 cons_elig;
  logic                 rdm_err;
  logic [MASK_W-1:0]    rdm_mask;
  logic [MASK_W-1:0]    rel_mask;
  logic                 rel_hit;
  logic                 want;
  logic                 emit_req;
  out_word_t            emit_word;
  logic                 out_free;
  logic                 go;
  logic                 out_load;

  assign owner_eff = owner_rvld_r ? own_rdata : MASK_W'(1);
  assign item_slot = SLOT_AW'(item_r.client_slot);
  assign item_bit  = slot_bit(item_slot);
  assign walk_bit  = slot_bit(slot_r);
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = CLIENT_SLOTS - 1; i >= 0; i--) begin
      if (!active_r[i]) begin
        free_found = 1'b1;
        free_slot  = SLOT_AW'(i);
      end
    end
  end

  assign cons_elig = active_r[slot_r] && (crd_rdata != '0) && (n_r < CNT_W'(MAX_RESULTS));
  assign rdm_err   = !slot_ok(item_r.client_slot) || !active_r[item_slot] ||
                     (item_r.has_buffer &&
                      (!buf_ok(item_r.buffer_index) || (owner_eff & item_bit) == '0));
  assign rdm_mask  = owner_eff & ~item_bit;
  assign rel_hit   = (owner_eff & item_bit) != '0;
  assign rel_mask  = owner_eff & ~item_bit;

  always_comb begin
    want      = 1'b0;
    emit_word = mk_word(KIND_ERROR, '0, '0, '0, '0);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_word.mode == MODE_CONNECT) begin
            want      = 1'b1;
            emit_word = free_found ? mk_word(KIND_ASSIGNED, SLOT_W'(free_slot), '0, '0, '0)
                                   : mk_word(KIND_NOSLOT, '0, '0, '0, '0);
          end else if (in_word.mode == MODE_RELEASE) begin
            want = !slot_ok(in_word.client_slot) ||
                   !active_r[SLOT_AW'(in_word.client_slot)];
          end
        end
      end
      S_CHECK: begin
        want = !buf_ok(item_r.buffer_index) || (owner_eff != MASK_W'(1));
      end
      S_CONS: begin
        want      = cons_elig;
        emit_word = mk_word(KIND_DELIVER, SLOT_W'(slot_r), item_r.buffer_index,
                            item_r.frame_sequence, item_r.frame_timestamp);
      end
      S_CFIN: begin
        want      = (mask_r == '0);
        emit_word = mk_word(KIND_RETURN, '0, item_r.buffer_index, '0, '0);
      end
      S_RDM: begin
        if (rdm_err) begin
          want = 1'b1;
        end else begin
          want      = item_r.has_buffer && (rdm_mask == '0);
          emit_word = mk_word(KIND_RETURN, '0, item_r.buffer_index, '0, '0);
        end
      end
      S_REL: begin
        want      = rel_hit && (rel_mask == '0);
        emit_word = mk_word(KIND_RETURN, '0, IDX_W'(buf_r), '0, '0);
      end
      S_FLUSH: begin
        want = 1'b0;
      end
      default: begin
        want = 1'b0;
      end
    endcase
  end

  assign emit_req = want && (n_r < CNT_W'(MAX_RESULTS));
  assign go       = !(emit_req && pend_valid_r && !out_free);

  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    slot_nxt       = slot_r;
    buf_nxt        = buf_r;
    mask_nxt       = mask_r;
    n_nxt          = n_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    active_nxt     = active_r;
    owner_vld_nxt  = owner_vld_r;
    own_req        = '0;
    crd_req        = '0;
    out_load       = 1'b0;
    out_nxt        = pend_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt = in_word;
          unique case (in_word.mode)
            MODE_CONSUME: begin
              own_req.raddr = BUF_AW'(in_word.buffer_index);
              state_nxt     = S_CHECK;
            end
            MODE_REDEEM: begin
              own_req.raddr = BUF_AW'(in_word.buffer_index);
              crd_req.raddr = SLOT_AW'(in_word.client_slot);
              state_nxt     = S_RDM;
            end
            MODE_RELEASE: begin
              if (slot_ok(in_word.client_slot) && active_r[SLOT_AW'(in_word.client_slot)]) begin
                active_nxt[SLOT_AW'(in_word.client_slot)] = 1'b0;
                crd_req.we    = 1'b1;
                crd_req.waddr = SLOT_AW'(in_word.client_slot);
                crd_req.wdata = '0;
                own_req.raddr = '0;
                buf_nxt       = '0;
                state_nxt     = S_REL;
              end else begin
                state_nxt = S_FLUSH;
              end
            end
            MODE_CONNECT: begin
              if (free_found) begin
                active_nxt[free_slot] = 1'b1;
                crd_req.we    = 1'b1;
                crd_req.waddr = free_slot;
                crd_req.wdata = '0;
              end
              state_nxt = S_FLUSH;
            end
            default: begin
              state_nxt = S_FLUSH;
            end
          endcase
        end
      end
      S_CHECK: begin
        if (want) begin
          state_nxt = S_FLUSH;
        end else begin
          crd_req.raddr = '0;
          slot_nxt      = '0;
          mask_nxt      = '0;
          state_nxt     = S_CONS;
        end
      end
      S_CONS: begin
        crd_req.raddr = go ? slot_r + SLOT_AW'(1) : slot_r;
        if (go) begin
          if (cons_elig) begin
            mask_nxt      = mask_r | walk_bit;
            crd_req.we    = 1'b1;
            crd_req.waddr = slot_r;
            crd_req.wdata = crd_rdata - CRD_W'(1);
          end
          if (32'(slot_r) == CLIENT_SLOTS - 1) begin
            state_nxt = S_CFIN;
          end else begin
            slot_nxt = slot_r + SLOT_AW'(1);
          end
        end
      end
      S_CFIN: begin
        if (go) begin
          own_req.we    = 1'b1;
          own_req.waddr = BUF_AW'(item_r.buffer_index);
          own_req.wdata = (mask_r == '0) ? MASK_W'(1) : mask_r;
          owner_vld_nxt[BUF_AW'(item_r.buffer_index)] = 1'b1;
          state_nxt     = S_FLUSH;
        end
      end
      S_RDM: begin
        if (!rdm_err) begin
          if (item_r.has_buffer) begin
            own_req.we    = 1'b1;
            own_req.waddr = BUF_AW'(item_r.buffer_index);
            own_req.wdata = (rdm_mask == '0) ? MASK_W'(1) : rdm_mask;
            owner_vld_nxt[BUF_AW'(item_r.buffer_index)] = 1'b1;
          end
          if (item_r.add_credit && crd_rdata < CRD_W'(CREDIT_MAX)) begin
            crd_req.we    = 1'b1;
            crd_req.waddr = item_slot;
            crd_req.wdata = crd_rdata + CRD_W'(1);
          end
        end
        state_nxt = S_FLUSH;
      end
      S_REL: begin
        own_req.raddr = go ? buf_r + BUF_AW'(1) : buf_r;
        if (go) begin
          if (rel_hit) begin
            own_req.we     = 1'b1;
            own_req.waddr  = buf_r;
            own_req.wdata  = (rel_mask == '0) ? MASK_W'(1) : rel_mask;
            owner_vld_nxt[buf_r] = 1'b1;
          end
          if (32'(buf_r) == BUFFER_COUNT - 1) begin
            state_nxt = S_FLUSH;
          end else begin
            buf_nxt = buf_r + BUF_AW'(1);
          end
        end
      end
      S_FLUSH: begin
        if (!pend_valid_r) begin
          n_nxt     = '0;
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_load       = 1'b1;
          out_nxt.last   = 1'b1;
          pend_valid_nxt = 1'b0;
          n_nxt          = '0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (go && emit_req) begin
      if (pend_valid_r) begin
        out_load = 1'b1;
      end
      pend_nxt       = emit_word;
      pend_valid_nxt = 1'b1;
      n_nxt          = n_r + CNT_W'(1);
    end
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      n_r          <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      active_r     <= '0;
      owner_vld_r  <= '0;
    end else begin
      state_r      <= state_nxt;
      n_r          <= n_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      active_r     <= active_nxt;
      owner_vld_r  <= owner_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    slot_r       <= slot_nxt;
    buf_r        <= buf_nxt;
    mask_r       <= mask_nxt;
    pend_r       <= pend_nxt;
    owner_rvld_r <= owner_vld_r[own_req.raddr];
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("Output register loaded while its word was still held.");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!pend_valid_r && n_r == '0))
    else $error("Pending result or count left over in idle.");

  a_mask_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    own_req.we |-> (own_req.wdata != '0))
    else $error("Owner mask written with no owner.");

  a_rel_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REL && own_req.we) |-> (own_req.raddr != own_req.waddr))
    else $error("Release walk reads the entry it writes.");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CNT_W'(MAX_RESULTS))
    else $error("Result count beyond its limit.");

endmodule
`default_nettype wire

// ----- src/shared_buffer_owner_tracker_top.sv -----
// One item is worked on at a time; in_stall stays high until its last word is in the
// output register. Consume walks the credit memory over every client slot and release
// walks the owner memory over every buffer; a refused consume or release skips its walk.
// Each word waits in a holding register until the next is formed, and in the flush state
// the last moves on from it into the output register once that register is free.
// Synchronous active-low reset: all buffers read as producer owned, all slots are free.
`default_nettype none
module shared_buffer_owner_tracker_top import sbot_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_word
);

  own_req_t          own_req;
  crd_req_t          crd_req;
  logic [MASK_W-1:0] own_rdata;
  logic [CRD_W-1:0]  crd_rdata;

  sbot_ram #(
    .WIDTH (MASK_W),
    .DEPTH (BUFFER_COUNT)
  ) u_owner_ram (
    .clk   (clk),
    .we    (own_req.we),
    .waddr (own_req.waddr),
    .wdata (own_req.wdata),
    .raddr (own_req.raddr),
    .rdata (own_rdata)
  );

  sbot_ram #(
    .WIDTH (CRD_W),
    .DEPTH (CLIENT_SLOTS)
  ) u_credit_ram (
    .clk   (clk),
    .we    (crd_req.we),
    .waddr (crd_req.waddr),
    .wdata (crd_req.wdata),
    .raddr (crd_req.raddr),
    .rdata (crd_rdata)
  );

  sbot_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .own_req   (own_req),
    .own_rdata (own_rdata),
    .crd_req   (crd_req),
    .crd_rdata (crd_rdata)
  );

endmodule
`default_nettype wire
